// ===== hdl/osa_edit_distance_core_macros.svh =====
// Assertion macros shared by the checker of the edit distance core.
`ifndef OSA_EDIT_DISTANCE_CORE_MACROS_SVH
`define OSA_EDIT_DISTANCE_CORE_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define OSA_ED_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is held.
`define OSA_ED_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/osa_ed_pkg.sv =====
// Shared constants, types and helpers of the edit distance core.
`default_nettype none

package osa_ed_pkg;

    // Capacity of each string in bytes.
    localparam int MAX_LEN  = 64;
    // Width of a length, a column index or a table value (holds 0..MAX_LEN).
    localparam int CW       = $clog2(MAX_LEN + 1);
    // Address width of the first string memory.
    localparam int AW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_W   = 8;
    localparam int REQ_W    = 2;
    localparam int DIST_W   = 7;
    localparam int DIST_CAP = 127;

    // Request codes of an input item.
    typedef enum logic [REQ_W-1:0] {
        REQ_FIRST   = 2'd0,
        REQ_SECOND  = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // One row step travelling from a cell to its right neighbor.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              trans_ok;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] pch;
        logic [CW-1:0]     left;
        logic [CW-1:0]     diag;
        logic [CW-1:0]     tdiag;
    } t_wave;

    // Byte load into the cell that holds one position of the second string.
    typedef struct packed {
        logic              en;
        logic [CW-1:0]     idx;
        logic [CHAR_W-1:0] ch;
    } t_load;

    // Clamp a table value to the distance field.
    function automatic logic [DIST_W-1:0] sat_dist(input logic [CW-1:0] v);
        logic [DIST_W-1:0] r;
        if (32'(v) > 32'(DIST_CAP)) begin
            r = DIST_W'(DIST_CAP);
        end else begin
            r = DIST_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/osa_edit_distance_core.sv =====
// Top level of the optimal string alignment distance core.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-------------------------------
//  in      | i_in_valid / o_in_ready   | i_req_type, i_char_code
//  out     | o_out_valid / i_out_ready | o_distance, o_overflow
//
// A compute item over two nonempty strings holds off the input until its result
// is captured, as each row steps through the column cells; with an empty first
// string the second length is registered as the result at once.
// Reset clears both lengths, the overflow flag and all control state.
// The result waits in an output register; appends are still taken while it
// waits, a new compute item is held off until the result is taken.
`default_nettype none

module osa_edit_distance_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [osa_ed_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [osa_ed_pkg::CHAR_W-1:0]     i_char_code,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [osa_ed_pkg::DIST_W-1:0]     o_distance,
    output logic                                   o_overflow
);

    localparam int N = osa_ed_pkg::MAX_LEN;

    osa_ed_pkg::t_state            r_state;
    osa_ed_pkg::t_state            n_state;
    logic [osa_ed_pkg::CW-1:0]     r_first_cnt;
    logic [osa_ed_pkg::CW-1:0]     r_second_cnt;
    logic                          r_ovf;
    logic                          r_cmp_ovf;
    logic [osa_ed_pkg::CW-1:0]     r_n;
    logic [osa_ed_pkg::CW-1:0]     r_m;
    logic [osa_ed_pkg::AW-1:0]     r_rd_addr;
    logic                          r_rd_pend;
    logic [osa_ed_pkg::CW-1:0]     r_src_row;
    osa_ed_pkg::t_wave             r_src;
    logic                          r_out_valid;
    logic [osa_ed_pkg::DIST_W-1:0] r_out_dist;
    logic                          r_out_ovf;

    logic                          in_fire;
    logic                          is_first;
    logic                          is_second;
    logic                          start_cmp;
    logic                          first_full;
    logic                          second_full;
    logic                          rd_en;
    logic                          done;
    logic                          cap;
    logic [osa_ed_pkg::CW-1:0]     cap_val;
    logic                          cap_ovf;
    logic [osa_ed_pkg::CHAR_W-1:0] ram_q;
    osa_ed_pkg::t_load             load;
    osa_ed_pkg::t_wave             sel;
    osa_ed_pkg::t_wave             wave    [0:N];
    logic [osa_ed_pkg::CHAR_W-1:0] cell_ch [0:N];

    // Input handshake: a compute item waits for a pending result to leave.
    assign o_in_ready = (r_state == osa_ed_pkg::ST_IDLE) &&
                        !(r_out_valid && (i_req_type == osa_ed_pkg::REQ_COMPUTE));
    assign in_fire    = i_in_valid && o_in_ready;

    // Request decode.
    always_comb begin
        is_first  = 1'b0;
        is_second = 1'b0;
        start_cmp = 1'b0;
        unique case (i_req_type)
            osa_ed_pkg::REQ_FIRST:   is_first  = in_fire;
            osa_ed_pkg::REQ_SECOND:  is_second = in_fire;
            osa_ed_pkg::REQ_COMPUTE: start_cmp = in_fire;
            default: ;
        endcase
    end

    assign first_full  = (r_first_cnt == osa_ed_pkg::CW'(N));
    assign second_full = (r_second_cnt == osa_ed_pkg::CW'(N));

    // First string memory.
    osa_ed_ram #(
        .WIDTH (osa_ed_pkg::CHAR_W),
        .DEPTH (N)
    ) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (is_first && !first_full),
        .i_waddr (r_first_cnt[osa_ed_pkg::AW-1:0]),
        .i_wdata (i_char_code),
        .i_re    (rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_q)
    );

    // Second string bytes go straight into the column cells.
    assign load.en  = is_second && !second_full;
    assign load.idx = r_second_cnt;
    assign load.ch  = i_char_code;

    // Column zero of the table is the row number itself.
    assign wave[0]    = r_src;
    assign cell_ch[0] = '0;

    // Row of column cells, one per byte of the second string.
    for (genvar j = 1; j <= N; j++) begin : g_cell
        osa_ed_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_col       (osa_ed_pkg::CW'(j)),
            .i_first_col (1'(j == 1)),
            .i_load      (load),
            .i_start     (start_cmp),
            .i_wave      (wave[j-1]),
            .i_left_ch   (cell_ch[j-1]),
            .o_ch        (cell_ch[j]),
            .o_wave      (wave[j])
        );
    end

    // The final table entry appears at the column of the second length.
    assign sel  = wave[r_m];
    assign done = sel.valid && sel.last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            osa_ed_pkg::ST_IDLE: begin
                if (start_cmp && (r_first_cnt != '0)) begin
                    n_state = osa_ed_pkg::ST_RUN;
                end
            end
            osa_ed_pkg::ST_RUN: begin
                if (r_rd_addr == osa_ed_pkg::AW'(r_n - osa_ed_pkg::CW'(1))) begin
                    n_state = osa_ed_pkg::ST_DRAIN;
                end
            end
            osa_ed_pkg::ST_DRAIN: begin
                if (done) begin
                    n_state = osa_ed_pkg::ST_IDLE;
                end
            end
            default: n_state = osa_ed_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        rd_en   = 1'b0;
        cap     = 1'b0;
        cap_val = sel.left;
        cap_ovf = r_cmp_ovf;
        unique case (r_state)
            osa_ed_pkg::ST_IDLE: begin
                // An empty first string gives the second length at once.
                cap     = start_cmp && (r_first_cnt == '0);
                cap_val = r_second_cnt;
                cap_ovf = r_ovf;
            end
            osa_ed_pkg::ST_RUN: begin
                rd_en = 1'b1;
            end
            osa_ed_pkg::ST_DRAIN: begin
                cap = done;
            end
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osa_ed_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // String lengths and the overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_ovf        <= 1'b0;
        end else if (start_cmp) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_ovf        <= 1'b0;
        end else begin
            if (is_first) begin
                if (first_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_first_cnt <= r_first_cnt + osa_ed_pkg::CW'(1);
                end
            end
            if (is_second) begin
                if (second_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_second_cnt <= r_second_cnt + osa_ed_pkg::CW'(1);
                end
            end
        end
    end

    // Snapshot of the lengths and flag for the running compute.
    always_ff @(posedge i_clk) begin
        if (start_cmp) begin
            r_n       <= r_first_cnt;
            r_m       <= r_second_cnt;
            r_cmp_ovf <= r_ovf;
        end
    end

    // Memory read sweep over the first string.
    always_ff @(posedge i_clk) begin
        if (start_cmp) begin
            r_rd_addr <= '0;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + osa_ed_pkg::AW'(1);
        end
    end

    // Row source: each first string byte starts one row of the table.
    always_ff @(posedge i_clk) begin
        // Valid of the read data and of the row source.
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_src.valid <= 1'b0;
        end else begin
            r_rd_pend   <= rd_en;
            r_src.valid <= r_rd_pend;
        end
        if (start_cmp) begin
            r_src_row <= '0;
        end else if (r_rd_pend) begin
            r_src_row      <= r_src_row + osa_ed_pkg::CW'(1);
            r_src.last     <= ((r_src_row + osa_ed_pkg::CW'(1)) == r_n);
            r_src.trans_ok <= (r_src_row != '0);
            r_src.ch       <= ram_q;
            r_src.pch      <= r_src.ch;
            r_src.left     <= r_src_row + osa_ed_pkg::CW'(1);
            r_src.diag     <= r_src_row;
            r_src.tdiag    <= '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cap) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap) begin
            r_out_dist <= osa_ed_pkg::sat_dist(cap_val);
            r_out_ovf  <= cap_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;
    assign o_overflow  = r_out_ovf;

endmodule

`default_nettype wire

// ===== hdl/osa_ed_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module osa_ed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/osa_ed_cell.sv =====
// One column cell of the systolic edit distance array.
`default_nettype none

module osa_ed_cell (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [osa_ed_pkg::CW-1:0]          i_col,
    input  wire logic                               i_first_col,
    input  wire osa_ed_pkg::t_load                  i_load,
    input  wire logic                               i_start,
    input  wire osa_ed_pkg::t_wave                  i_wave,
    input  wire logic [osa_ed_pkg::CHAR_W-1:0]      i_left_ch,
    output logic      [osa_ed_pkg::CHAR_W-1:0]      o_ch,
    output osa_ed_pkg::t_wave                       o_wave
);

    logic [osa_ed_pkg::CHAR_W-1:0] r_ch;
    logic [osa_ed_pkg::CW-1:0]     r_prev;
    logic [osa_ed_pkg::CW-1:0]     r_hold;
    osa_ed_pkg::t_wave             r_wave;

    logic                          cost;
    logic                          trans;
    logic [osa_ed_pkg::CW:0]       s_up;
    logic [osa_ed_pkg::CW:0]       s_left;
    logic [osa_ed_pkg::CW:0]       s_diag;
    logic [osa_ed_pkg::CW:0]       s_tr;
    logic [osa_ed_pkg::CW:0]       m_a;
    logic [osa_ed_pkg::CW:0]       m_b;
    logic [osa_ed_pkg::CW:0]       m_c;
    logic [osa_ed_pkg::CW-1:0]     n_val;

    // Table entry for this column: the cheapest of insert, delete,
    // substitute and, where the bytes cross, transpose.
    always_comb begin
        cost   = (i_wave.ch != r_ch);
        s_up   = {1'b0, r_prev} + {{osa_ed_pkg::CW{1'b0}}, 1'b1};
        s_left = {1'b0, i_wave.left} + {{osa_ed_pkg::CW{1'b0}}, 1'b1};
        s_diag = {1'b0, i_wave.diag} + {{osa_ed_pkg::CW{1'b0}}, cost};
        s_tr   = {1'b0, i_wave.tdiag} + {{osa_ed_pkg::CW{1'b0}}, 1'b1};
        trans  = !i_first_col && i_wave.trans_ok &&
                 (i_wave.ch == i_left_ch) && (i_wave.pch == r_ch);
        m_a    = (s_up < s_left) ? s_up : s_left;
        m_b    = (s_diag < m_a) ? s_diag : m_a;
        m_c    = (trans && (s_tr < m_b)) ? s_tr : m_b;
        n_val  = m_c[osa_ed_pkg::CW-1:0];
    end

    // Byte of the second string held by this column.
    always_ff @(posedge i_clk) begin
        if (i_load.en && (i_load.idx == (i_col - osa_ed_pkg::CW'(1)))) begin
            r_ch <= i_load.ch;
        end
    end

    // Column state and the step handed to the neighbor.
    always_ff @(posedge i_clk) begin
        // Step valid moves one cell to the right each cycle.
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= i_wave.valid;
        end
        if (i_start) begin
            r_prev <= i_col;
        end else if (i_wave.valid) begin
            r_prev          <= n_val;
            r_hold          <= i_wave.diag;
            r_wave.last     <= i_wave.last;
            r_wave.trans_ok <= i_wave.trans_ok;
            r_wave.ch       <= i_wave.ch;
            r_wave.pch      <= i_wave.pch;
            r_wave.left     <= n_val;
            r_wave.diag     <= r_prev;
            r_wave.tdiag    <= r_hold;
        end
    end

    assign o_ch   = r_ch;
    assign o_wave = r_wave;

endmodule

`default_nettype wire

// ===== hdl/osa_ed_checker.sv =====
// Port level checks of the edit distance core and their binding.
`default_nettype none

`include "osa_edit_distance_core_macros.svh"

module osa_ed_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic [osa_ed_pkg::REQ_W-1:0]  i_req_type,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [osa_ed_pkg::DIST_W-1:0] i_distance
);

    // A pending result is not withdrawn.
    `OSA_ED_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result withdrawn before it was taken")

    // Reset leaves no result pending.
    `OSA_ED_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid, "result pending after reset")

    // A distance never exceeds the string capacity.
    `OSA_ED_ASSERT(a_dist_bound, i_clk, i_rst_n, i_out_valid |-> (32'(i_distance) <= 32'(osa_ed_pkg::MAX_LEN)), "distance above capacity")

    // A compute item either gives its result at once or blocks further items.
    `OSA_ED_ASSERT(a_compute_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_req_type == osa_ed_pkg::REQ_COMPUTE) |=> !i_in_ready || i_out_valid, "items taken while a compute runs")

endmodule

bind osa_edit_distance_core osa_ed_checker u_osa_ed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_req_type  (i_req_type),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_distance  (o_distance)
);

`default_nettype wire

// ===== test/osa_edit_distance_core_tb.sv =====
// Self-checking testbench for the optimal string alignment distance core.
module osa_edit_distance_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W    = osa_ed_pkg::REQ_W;
    localparam int CHAR_W   = osa_ed_pkg::CHAR_W;
    localparam int DIST_W   = osa_ed_pkg::DIST_W;
    localparam int MAX_LEN  = osa_ed_pkg::MAX_LEN;
    localparam int DIST_CAP = osa_ed_pkg::DIST_CAP;

    // Request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // Cycles without any item moving before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Quiet cycles after the last result, longer than the slowest compute.
    localparam int TAIL_CYCLES = 200;
    // Receiver hold-off that backs the block up, and where it starts.
    localparam int HOLD_CYCLES = 1000;
    localparam int HOLD_AFTER  = 300;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] code;
        bit                drain_first;
    } t_item;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [REQ_W-1:0] req_reg = '0;
    logic [CHAR_W-1:0] code_reg = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic [DIST_W-1:0] o_distance;
    logic o_overflow;

    t_item pending[$];
    t_outcome distances_due[$];
    int mismatches = 0;
    int items_taken = 0;

    // Predicted contents of the two strings.
    logic [CHAR_W-1:0] text_a [MAX_LEN];
    logic [CHAR_W-1:0] text_b [MAX_LEN];
    int len_a = 0;
    int len_b = 0;
    bit byte_dropped = 1'b0;

    osa_edit_distance_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (req_reg),
        .i_char_code (code_reg),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_distance  (o_distance),
        .o_overflow  (o_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Row-by-row alignment table over the loaded strings, with adjacent swaps.
    function automatic logic [DIST_W-1:0] align_distance();
        int older [MAX_LEN+1];
        int prior [MAX_LEN+1];
        int row [MAX_LEN+1];
        int v;
        int cost;
        for (int j = 0; j <= len_b; j++) begin
            prior[j] = j;
            older[j] = j;
        end
        for (int i = 1; i <= len_a; i++) begin
            row[0] = i;
            for (int j = 1; j <= len_b; j++) begin
                cost = (text_a[i-1] == text_b[j-1]) ? 0 : 1;
                v = prior[j] + 1;
                if (row[j-1] + 1 < v) v = row[j-1] + 1;
                if (prior[j-1] + cost < v) v = prior[j-1] + cost;
                if (i > 1 && j > 1) begin
                    if (text_a[i-1] == text_b[j-2] && text_a[i-2] == text_b[j-1]
                            && older[j-2] + 1 < v) begin
                        v = older[j-2] + 1;
                    end
                end
                row[j] = v;
            end
            older = prior;
            prior = row;
        end
        if (prior[len_b] > DIST_CAP) begin
            return DIST_W'(DIST_CAP);
        end
        return DIST_W'(prior[len_b]);
    endfunction

    // Update the predicted strings for one accepted item; queue any result.
    task automatic apply_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] code);
        t_outcome want;
        case (req)
            osa_ed_pkg::REQ_FIRST: begin
                if (len_a < MAX_LEN) begin
                    text_a[len_a] = code;
                    len_a++;
                end else begin
                    byte_dropped = 1'b1;
                end
            end
            osa_ed_pkg::REQ_SECOND: begin
                if (len_b < MAX_LEN) begin
                    text_b[len_b] = code;
                    len_b++;
                end else begin
                    byte_dropped = 1'b1;
                end
            end
            osa_ed_pkg::REQ_COMPUTE: begin
                want.distance = align_distance();
                want.overflow = byte_dropped;
                distances_due = {distances_due, want};
                len_a = 0;
                len_b = 0;
                byte_dropped = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_item(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] code,
                            input bit drain_first);
        t_item it;
        it.req = req;
        it.code = code;
        it.drain_first = drain_first;
        pending = {pending, it};
    endtask

    // Build one pair of strings, interleave their appends, then compute.
    task automatic add_pair(input bit drain_first, inout int useful);
        logic [CHAR_W-1:0] sa[$];
        logic [CHAR_W-1:0] sb[$];
        logic [CHAR_W-1:0] tmp;
        int kind;
        int n;
        int m;
        int ia;
        int ib;
        int edits;
        int pos;
        bit wide;
        bit lead;
        logic [CHAR_W-1:0] base;
        kind = $urandom_range(0, 99);
        wide = ($urandom_range(0, 3) == 0);
        base = CHAR_W'($urandom_range(0, 251));
        lead = drain_first;
        if (kind < 77) begin
            n = $urandom_range(0, 8);
        end else if (kind < 92) begin
            n = $urandom_range(0, 20);
        end else if (kind < 96) begin
            n = $urandom_range(40, MAX_LEN);
        end else begin
            n = $urandom_range(MAX_LEN - 2, MAX_LEN + 6);
        end
        for (int k = 0; k < n; k++) begin
            tmp = wide ? CHAR_W'($urandom_range(0, 255)) : base + CHAR_W'($urandom_range(0, 3));
            sa = {sa, tmp};
        end
        if (kind < 92 && $urandom_range(0, 3) != 0) begin
            // Second string is a lightly edited copy, so swaps and matches occur.
            sb = sa;
            edits = $urandom_range(0, 3);
            for (int k = 0; k < edits; k++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        if (sb.size() >= 2) begin
                            pos = $urandom_range(0, sb.size() - 2);
                            tmp = sb[pos];
                            sb[pos] = sb[pos+1];
                            sb[pos+1] = tmp;
                        end
                    end
                    1: begin
                        if (sb.size() >= 1) begin
                            pos = $urandom_range(0, sb.size() - 1);
                            sb[pos] = sb[pos] ^ 8'h20;
                        end
                    end
                    2: begin
                        if (sb.size() >= 1) begin
                            sb.delete($urandom_range(0, sb.size() - 1));
                        end
                    end
                    default: begin
                        sb.insert($urandom_range(0, sb.size()), base + CHAR_W'($urandom_range(0, 3)));
                    end
                endcase
            end
        end else begin
            m = (kind < 92) ? $urandom_range(0, 20) : $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
            for (int k = 0; k < m; k++) begin
                tmp = wide ? CHAR_W'($urandom_range(0, 255)) : base + CHAR_W'($urandom_range(0, 3));
                sb = {sb, tmp};
            end
        end
        ia = 0;
        ib = 0;
        while (ia < sa.size() || ib < sb.size()) begin
            if ($urandom_range(0, 19) == 0) begin
                add_item(REQ_UNUSED, CHAR_W'($urandom_range(0, 255)), lead);
                lead = 1'b0;
            end
            if (ib >= sb.size() || (ia < sa.size() && $urandom_range(0, 1) == 1)) begin
                add_item(osa_ed_pkg::REQ_FIRST, sa[ia], lead);
                ia++;
            end else begin
                add_item(osa_ed_pkg::REQ_SECOND, sb[ib], lead);
                ib++;
            end
            lead = 1'b0;
            useful++;
        end
        add_item(osa_ed_pkg::REQ_COMPUTE, CHAR_W'($urandom_range(0, 255)), lead);
        useful++;
        // Occasionally a stray compute right after, on empty strings.
        if ($urandom_range(0, 19) == 0) begin
            add_item(osa_ed_pkg::REQ_COMPUTE, 8'h00, 1'b0);
            useful++;
        end
    endtask

    // Stimulus, reset and end of run.
    initial begin
        int useful;
        bit drained_mid;
        useful = 0;
        drained_mid = 1'b0;

        // Both strings empty, then the unused code, then byte extremes.
        add_item(osa_ed_pkg::REQ_COMPUTE, 8'hFF, 1'b0);
        add_item(REQ_UNUSED, 8'hFF, 1'b0);
        add_item(osa_ed_pkg::REQ_FIRST, 8'h00, 1'b0);
        add_item(osa_ed_pkg::REQ_COMPUTE, 8'h00, 1'b0);
        add_item(osa_ed_pkg::REQ_SECOND, 8'hFF, 1'b0);
        add_item(osa_ed_pkg::REQ_SECOND, 8'h00, 1'b0);
        add_item(osa_ed_pkg::REQ_COMPUTE, 8'h00, 1'b0);
        // Adjacent transposition costs one.
        add_item(osa_ed_pkg::REQ_FIRST, "a", 1'b0);
        add_item(osa_ed_pkg::REQ_FIRST, "b", 1'b0);
        add_item(osa_ed_pkg::REQ_SECOND, "b", 1'b0);
        add_item(osa_ed_pkg::REQ_SECOND, "a", 1'b0);
        add_item(osa_ed_pkg::REQ_COMPUTE, 8'h00, 1'b0);
        // Case is significant.
        add_item(osa_ed_pkg::REQ_FIRST, "a", 1'b0);
        add_item(osa_ed_pkg::REQ_SECOND, "A", 1'b0);
        add_item(osa_ed_pkg::REQ_COMPUTE, 8'h00, 1'b0);
        // Equal bytes with an ignored item in between.
        add_item(osa_ed_pkg::REQ_FIRST, 8'h55, 1'b0);
        add_item(osa_ed_pkg::REQ_SECOND, 8'h55, 1'b0);
        add_item(REQ_UNUSED, 8'hAA, 1'b0);
        add_item(osa_ed_pkg::REQ_COMPUTE, 8'h00, 1'b0);

        // Random pairs; the sender drains fully before the first and once midway.
        add_pair(1'b1, useful);
        while (useful < RANDOM_ITEMS) begin
            if (!drained_mid && useful > RANDOM_ITEMS / 2) begin
                drained_mid = 1'b1;
                add_pair(1'b1, useful);
            end else begin
                add_pair(1'b0, useful);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid) @(posedge i_clk);
        while (distances_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        t_item head;
        bit held;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            held = in_valid && !o_in_ready;
            if (in_valid && o_in_ready) begin
                apply_request(req_reg, code_reg);
                items_taken <= items_taken + 1;
            end
            if (!held) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending.size() != 0 &&
                             !(pending[0].drain_first && distances_due.size() != 0)) begin
                    head = pending.pop_front();
                    in_valid <= 1'b1;
                    req_reg <= head.req;
                    code_reg <= head.code;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: phases of always ready, coin flips and heavy stalls,
    // plus one long hold-off that backs the block up.
    int hold_left = 0;
    bit hold_done = 1'b0;
    int phase_left = 0;
    int phase_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_mode <= $urandom_range(0, 2);
                phase_left <= $urandom_range(5, 60);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (phase_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Compare each taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (distances_due.size() == 0) begin
                $display("%0t: result with none expected: distance %0d overflow %0b",
                         $realtime, o_distance, o_overflow);
                mismatches++;
            end else begin
                want = distances_due.pop_front();
                if (o_distance !== want.distance) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $realtime, want.distance, o_distance);
                    mismatches++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $realtime, want.overflow, o_overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
